FILE: src/hmkbs_pkg.sv
// hmkbs_pkg: types and constants shared by the haptic kick/brake sequencer
// covers configuration layout, sequencer phases, state and result records
// no dependencies
package hmkbs_pkg;

	// configuration register indexes
	localparam logic [2:0] CFG_DRIVE_GAIN   = 3'd0;
	localparam logic [2:0] CFG_MAX_ON_MS    = 3'd1;
	localparam logic [2:0] CFG_BRAKE_MS     = 3'd2;
	localparam logic [2:0] CFG_KICK_MS      = 3'd3;
	localparam logic [2:0] CFG_OVERDRIVE_ON = 3'd4;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// configuration reset values
	localparam logic signed [8:0] RST_DRIVE_GAIN   = 9'sd128;
	localparam logic [15:0]       RST_MAX_ON_MS    = 16'd30000;
	localparam logic [6:0]        RST_BRAKE_MS     = 7'd20;
	localparam logic [6:0]        RST_KICK_MS      = 7'd20;
	localparam logic              RST_OVERDRIVE_ON = 1'b1;

	// drive levels and timing constants
	localparam logic signed [8:0]  KICK_LEVEL     = 9'sd128;
	localparam logic signed [8:0]  BRAKE_LEVEL    = -9'sd125;
	localparam logic signed [8:0]  GAIN_MAX       = 9'sd128;
	localparam logic signed [8:0]  GAIN_MIN       = -9'sd128;
	localparam logic [6:0]         SHORT_BRAKE_MS = 7'd5;
	localparam logic [7:0]         LONG_RUN_MIN   = 8'd40;
	localparam logic signed [15:0] CONT_MS        = -16'sd100;

	// item kinds
	localparam logic KIND_TICK   = 1'b0;
	localparam logic KIND_ENABLE = 1'b1;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_KICK_TIMED,
		PH_KICK_CONT,
		PH_RUN_TIMED,
		PH_RUN_CONT,
		PH_BRAKE
	} phase_t;

	typedef struct packed {
		logic signed [8:0] drive_gain;
		logic [15:0]       max_on_ms;
		logic [6:0]        brake_ms;
		logic [6:0]        kick_ms;
		logic              overdrive_on;
	} cfg_t;

	typedef struct packed {
		phase_t      phase;
		logic [15:0] count;
		logic [15:0] pending;
		logic        long_brake;
		logic        active;
	} seq_state_t;

	typedef struct packed {
		logic              pwm_enable;
		logic signed [8:0] pwm_level;
		logic              power_on;
		logic              ic_enable;
		logic [15:0]       remaining_ms;
	} result_t;

endpackage

FILE: src/haptic_motor_kick_brake_sequencer_unit.sv
// Haptic motor kick/brake sequencer, top level.
// An item passes the input register, then its result is registered at the output.
// Throughput: one item per cycle unless m_tready stalls the output register.
// The output register lets a new item in while a result waits to be taken.
// Reset (arst_n low, asynchronous): phase idle, counters clear, config to defaults.
// depends on hmkbs_pkg, hmkbs_cfg, hmkbs_seq
module haptic_motor_kick_brake_sequencer_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration
	input  logic                                 cfg_we,
	input  logic [hmkbs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [hmkbs_pkg::CFG_DATA_W-1:0]     cfg_data,
	// input items
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [15:0]                          s_tdata,  // [15:0] value_ms
	input  logic                                 s_tuser,  // [0] kind
	// result items
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// [0] pwm_enable, [9:1] pwm_level, [10] power_on, [11] ic_enable,
	// [27:12] remaining_ms, [31:28] zero
	output logic [31:0]                          m_tdata
);

	hmkbs_pkg::cfg_t    cfg;
	hmkbs_pkg::result_t result;

	logic              valid_s1;
	logic              kind_s1;
	logic signed [15:0] value_s1;
	logic              valid_s2;
	logic [31:0]       data_s2;
	logic              out_free;
	logic              adv;

	// handshake
	assign out_free = !valid_s2 || m_tready;
	assign adv      = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	hmkbs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	hmkbs_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.kind     (kind_s1),
		.value_ms (value_s1),
		.cfg      (cfg),
		.result   (result)
	);

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) valid_s1 <= s_tvalid;
			if (out_free) valid_s2 <= valid_s1;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			kind_s1  <= s_tuser;
			value_s1 <= s_tdata;
		end
		if (adv) begin
			data_s2 <= {4'd0, result.remaining_ms, result.ic_enable, result.power_on,
				result.pwm_level, result.pwm_enable};
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = data_s2;

endmodule

FILE: src/hmkbs_cfg.sv
// hmkbs_cfg: configuration register bank of the haptic kick/brake sequencer
// depends on hmkbs_pkg for register indexes, reset values and cfg_t
module hmkbs_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [hmkbs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [hmkbs_pkg::CFG_DATA_W-1:0]    cfg_data,
	output hmkbs_pkg::cfg_t                     cfg
);

	hmkbs_pkg::cfg_t cfg_q;

	// register writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.drive_gain   <= hmkbs_pkg::RST_DRIVE_GAIN;
			cfg_q.max_on_ms    <= hmkbs_pkg::RST_MAX_ON_MS;
			cfg_q.brake_ms     <= hmkbs_pkg::RST_BRAKE_MS;
			cfg_q.kick_ms      <= hmkbs_pkg::RST_KICK_MS;
			cfg_q.overdrive_on <= hmkbs_pkg::RST_OVERDRIVE_ON;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hmkbs_pkg::CFG_DRIVE_GAIN:   cfg_q.drive_gain   <= cfg_data[8:0];
				hmkbs_pkg::CFG_MAX_ON_MS:    cfg_q.max_on_ms    <= cfg_data[15:0];
				hmkbs_pkg::CFG_BRAKE_MS:     cfg_q.brake_ms     <= cfg_data[6:0];
				hmkbs_pkg::CFG_KICK_MS:      cfg_q.kick_ms      <= cfg_data[6:0];
				hmkbs_pkg::CFG_OVERDRIVE_ON: cfg_q.overdrive_on <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: src/hmkbs_seq.sv
// hmkbs_seq: phase state machine of the haptic kick/brake sequencer
// holds phase, counters and brake mode; computes the result for each item
// depends on hmkbs_pkg
module hmkbs_seq (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  logic                     kind,
	input  logic signed [15:0]       value_ms,
	input  hmkbs_pkg::cfg_t          cfg,
	output hmkbs_pkg::result_t       result
);

	hmkbs_pkg::seq_state_t st_q;
	hmkbs_pkg::seq_state_t nx;

	// drop to idle, brake mode kept
	function automatic hmkbs_pkg::seq_state_t go_idle(input hmkbs_pkg::seq_state_t st);
		hmkbs_pkg::seq_state_t r;
		r         = st;
		r.phase   = hmkbs_pkg::PH_IDLE;
		r.count   = 16'd0;
		r.pending = 16'd0;
		r.active  = 1'b0;
		return r;
	endfunction

	function automatic hmkbs_pkg::seq_state_t turn_off(input hmkbs_pkg::seq_state_t st,
			input logic od, input logic [6:0] brk);
		hmkbs_pkg::seq_state_t r;
		logic [6:0] t;
		r = st;
		t = st.long_brake ? brk : hmkbs_pkg::SHORT_BRAKE_MS;
		if (!od) begin
			r = go_idle(st);
		end else if (st.active) begin
			r = go_idle(st);
			if (t != 7'd0) begin
				r.phase = hmkbs_pkg::PH_BRAKE;
				r.count = {9'd0, t};
			end
		end
		return r;
	endfunction

	function automatic hmkbs_pkg::seq_state_t enter_run(input hmkbs_pkg::seq_state_t st,
			input logic timed, input logic [15:0] ms, input logic od, input logic [6:0] brk);
		hmkbs_pkg::seq_state_t r;
		r         = st;
		r.active  = 1'b1;
		r.pending = 16'd0;
		if (!timed) begin
			r.phase = hmkbs_pkg::PH_RUN_CONT;
			r.count = 16'd0;
		end else begin
			r.phase = hmkbs_pkg::PH_RUN_TIMED;
			r.count = ms;
			if (ms == 16'd0) r = turn_off(r, od, brk);
		end
		return r;
	endfunction

	function automatic hmkbs_pkg::seq_state_t turn_on(input hmkbs_pkg::seq_state_t st,
			input logic timed, input logic [15:0] ms, input hmkbs_pkg::cfg_t c);
		hmkbs_pkg::seq_state_t r;
		r = st;
		if (!c.overdrive_on || c.kick_ms == 7'd0) begin
			r = enter_run(st, timed, ms, c.overdrive_on, c.brake_ms);
		end else begin
			r.active  = 1'b1;
			r.phase   = timed ? hmkbs_pkg::PH_KICK_TIMED : hmkbs_pkg::PH_KICK_CONT;
			r.count   = {9'd0, c.kick_ms};
			r.pending = timed ? ms : 16'd0;
		end
		return r;
	endfunction

	// run level, clamped to the drive range
	logic signed [8:0] gain_lvl;
	always_comb begin
		priority if (cfg.drive_gain > hmkbs_pkg::GAIN_MAX) gain_lvl = hmkbs_pkg::GAIN_MAX;
		else if (cfg.drive_gain < hmkbs_pkg::GAIN_MIN) gain_lvl = hmkbs_pkg::GAIN_MIN;
		else gain_lvl = cfg.drive_gain;
	end

	// requested duration: clamp, then shorten in overdrive mode
	logic        cmd_pos;
	logic [15:0] dur_clamp;
	logic [15:0] long_min;
	logic        lb_new;
	logic [15:0] dur;
	always_comb begin
		cmd_pos   = !value_ms[15] && (value_ms != 16'sd0);
		dur_clamp = (value_ms[15:0] > cfg.max_on_ms) ? cfg.max_on_ms : value_ms[15:0];
		long_min  = {8'd0, hmkbs_pkg::LONG_RUN_MIN} + {9'd0, cfg.brake_ms};
		lb_new    = (dur_clamp >= long_min);
		dur       = dur_clamp;
		if (cfg.overdrive_on) begin
			if (lb_new) dur = dur_clamp - {9'd0, cfg.brake_ms};
			else if (dur_clamp > {9'd0, hmkbs_pkg::SHORT_BRAKE_MS})
				dur = dur_clamp - {9'd0, hmkbs_pkg::SHORT_BRAKE_MS};
			else dur = 16'd0;
		end
	end

	// next state for one item
	always_comb begin
		nx = st_q;
		if (kind == hmkbs_pkg::KIND_ENABLE) begin
			priority if (cmd_pos) begin
				if (cfg.overdrive_on) nx.long_brake = lb_new;
				if (cfg.drive_gain == 9'sd0) nx = turn_off(nx, cfg.overdrive_on, cfg.brake_ms);
				else nx = turn_on(nx, 1'b1, dur, cfg);
			end else if (value_ms == hmkbs_pkg::CONT_MS) begin
				if (cfg.drive_gain == 9'sd0) nx = turn_off(nx, cfg.overdrive_on, cfg.brake_ms);
				else nx = turn_on(nx, 1'b0, 16'd0, cfg);
			end else begin
				nx = turn_off(nx, cfg.overdrive_on, cfg.brake_ms);
			end
		end else begin
			unique case (st_q.phase)
				hmkbs_pkg::PH_KICK_TIMED, hmkbs_pkg::PH_KICK_CONT: begin
					if (st_q.count <= 16'd1)
						nx = enter_run(st_q, st_q.phase == hmkbs_pkg::PH_KICK_TIMED,
							st_q.pending, cfg.overdrive_on, cfg.brake_ms);
					else nx.count = st_q.count - 16'd1;
				end
				hmkbs_pkg::PH_RUN_TIMED: begin
					if (st_q.count <= 16'd1) begin
						nx.count = 16'd0;
						nx = turn_off(nx, cfg.overdrive_on, cfg.brake_ms);
					end else nx.count = st_q.count - 16'd1;
				end
				hmkbs_pkg::PH_BRAKE: begin
					if (st_q.count <= 16'd1) nx = go_idle(st_q);
					else nx.count = st_q.count - 16'd1;
				end
				default: ;
			endcase
		end
	end

	// state register, updated once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase      <= hmkbs_pkg::PH_IDLE;
			st_q.count      <= 16'd0;
			st_q.pending    <= 16'd0;
			st_q.long_brake <= 1'b0;
			st_q.active     <= 1'b0;
		end else if (adv) begin
			st_q <= nx;
		end
	end

	// drive outputs from the phase after the item
	always_comb begin
		result = '0;
		unique case (nx.phase)
			hmkbs_pkg::PH_KICK_TIMED, hmkbs_pkg::PH_KICK_CONT: begin
				result.pwm_enable = 1'b1;
				result.pwm_level  = hmkbs_pkg::KICK_LEVEL;
				result.power_on   = 1'b1;
			end
			hmkbs_pkg::PH_RUN_TIMED, hmkbs_pkg::PH_RUN_CONT: begin
				result.pwm_enable = 1'b1;
				result.pwm_level  = gain_lvl;
				result.power_on   = 1'b1;
				result.ic_enable  = 1'b1;
				if (nx.phase == hmkbs_pkg::PH_RUN_TIMED) result.remaining_ms = nx.count;
			end
			hmkbs_pkg::PH_BRAKE: begin
				result.pwm_enable = 1'b1;
				result.pwm_level  = hmkbs_pkg::BRAKE_LEVEL;
				result.power_on   = 1'b1;
				result.ic_enable  = 1'b1;
			end
			default: ;
		endcase
	end

`ifndef SYNTH
	// drive is active exactly in kick and run phases
	a_active_phase: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.active == (st_q.phase == hmkbs_pkg::PH_KICK_TIMED ||
			st_q.phase == hmkbs_pkg::PH_KICK_CONT || st_q.phase == hmkbs_pkg::PH_RUN_TIMED ||
			st_q.phase == hmkbs_pkg::PH_RUN_CONT))
		else $error("drive_active out of step with phase");

	// idle carries no count and no pending run
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.phase == hmkbs_pkg::PH_IDLE |-> st_q.count == 16'd0 && st_q.pending == 16'd0)
		else $error("idle phase with leftover count");

	// counted phases never hold a zero count
	a_count_live: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.phase == hmkbs_pkg::PH_BRAKE || st_q.phase == hmkbs_pkg::PH_KICK_TIMED ||
			st_q.phase == hmkbs_pkg::PH_KICK_CONT || st_q.phase == hmkbs_pkg::PH_RUN_TIMED)
		|-> st_q.count != 16'd0)
		else $error("counted phase with zero count");

	// last brake tick ends in idle
	a_brake_end: assert property (@(posedge clk) disable iff (!arst_n)
		adv && kind == hmkbs_pkg::KIND_TICK && st_q.phase == hmkbs_pkg::PH_BRAKE &&
			st_q.count == 16'd1 |=> st_q.phase == hmkbs_pkg::PH_IDLE)
		else $error("brake did not end on its last tick");
`endif

endmodule
